### src/tbsd_pkg.sv
// ----------------------------------------------------------------------------
// tbsd_pkg
// Shared types and fixed constants of the triple buffer scrub delay.
// ----------------------------------------------------------------------------
package tbsd_pkg;

    localparam int CFG_W       = 18;      // width of a configuration value
    localparam int CFG_IDX_W   = 2;       // width of a register index
    localparam int GAIN_BITS   = 16;      // crossfade gains are Q1.16
    localparam int RESET_DELAY = 131072;  // delay_len after reset
    localparam int RESET_SPAN  = 4410;    // overlap_len and ramp_len after reset

    localparam logic [1:0] BANK_LAST = 2'd2;  // highest of the three buffers

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY   = 2'd0,
        REG_OVERLAP = 2'd1,
        REG_RAMP    = 2'd2,
        REG_POWER   = 2'd3
    } t_reg_idx;

    // request strobes towards the sample store
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### src/tbsd_div.sv
// ----------------------------------------------------------------------------
// tbsd_div
// Restoring divider, one quotient bit a cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module tbsd_div import tbsd_pkg::*; #(
    parameter int W = 41
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output t_div_stat    o_stat,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         fits;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_quo;

    // shift in the next dividend bit, subtract where the divisor fits
    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = trial >= {1'b0, r_div};
        n_rem = fits ? diff[W-1:0] : trial[W-1:0];
        n_quo = {r_quo[W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### src/tbsd_store.sv
// ----------------------------------------------------------------------------
// tbsd_store
// Sample memory of the three buffers, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module tbsd_store import tbsd_pkg::*; #(
    parameter int IDX_W  = 17,
    parameter int DATA_W = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mem_ctl                 i_ctl,
    input  logic [IDX_W+1:0]         i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic [IDX_W+1:0]         i_raddr,
    output logic signed [DATA_W-1:0] o_rdata,
    output logic                     o_clearing
);

    localparam int AW        = IDX_W + 2;
    localparam int MEM_DEPTH = 3 * (2 ** IDX_W);

    logic signed [DATA_W-1:0] mem [MEM_DEPTH];
    logic signed [DATA_W-1:0] r_rdata;
    logic                     r_clr_busy;
    logic [AW-1:0]            r_clr_addr;

    // sweep every entry once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MEM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_ctl.we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clr_busy;

endmodule

### src/triple_buffer_scrub_delay.sv
// ----------------------------------------------------------------------------
// triple_buffer_scrub_delay
// Scrubbing delay: records into one of three rotating buffers and crossfades
// interpolated playback of the other two.
// ----------------------------------------------------------------------------
//  channel   direction  request fields (low bit up)
//  s_axis    in         tdata: in_sample, scrub_rate, zero fill
//  m_axis    out        tdata: out_sample, zero fill
//  cfg       in         i_cfg_index, i_cfg_data (write only, always ready)
//
//  One request at a time. A powered request runs one division on the
//  one-bit-a-cycle divider for each position wrap (two) and for each ramp or
//  gain below full scale (up to three more). A request taken with power off
//  goes straight to the output state. After reset the sample memory is swept
//  clear, all 3 * 2**ceil(log2(BUFFER_DEPTH)) entries, with s_axis_tready
//  low; writes on the cfg channel are taken throughout. A stalled result waits
//  in the output register while the next request is already taken.
// ----------------------------------------------------------------------------
module triple_buffer_scrub_delay import tbsd_pkg::*; #(
    parameter int BUFFER_DEPTH = 131072,
    parameter int SAMPLE_BITS  = 24,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    // in_sample, scrub_rate, zero fill
    input  logic [((SAMPLE_BITS+FRAC_BITS+4+7)/8)*8-1:0] s_axis_tdata,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    // out_sample, zero fill
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]              m_axis_tdata,
    input  logic                                           i_cfg_valid,
    output logic                                           o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                           i_cfg_index,
    input  logic [CFG_W-1:0]                               i_cfg_data
);

    localparam int S      = SAMPLE_BITS;
    localparam int F      = FRAC_BITS;
    localparam int IDX_W  = $clog2(BUFFER_DEPTH);
    localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int RATE_W = F + 4;
    localparam int POS_W  = LEN_W + F + 1;
    localparam int LF_W   = LEN_W + F;
    localparam int DW_A   = S + LEN_W;
    localparam int DW_B   = (POS_W > DW_A) ? POS_W : DW_A;
    localparam int DW     = ((LEN_W + GAIN_BITS) > DW_B) ? (LEN_W + GAIN_BITS) : DW_B;
    localparam int MB_A   = ((F + 1) > LEN_W) ? (F + 1) : LEN_W;
    localparam int MB_W   = (((GAIN_BITS + 1) > MB_A) ? (GAIN_BITS + 1) : MB_A) + 1;
    localparam int PW     = S + MB_W;
    localparam int SUM_W  = PW + 1;
    localparam int AW     = IDX_W + 2;
    localparam int CW     = (CFG_W > LEN_W) ? CFG_W : LEN_W;

    localparam logic signed [PW-1:0]    HALF_F = PW'(64'd1 << (F - 1));
    localparam logic signed [SUM_W-1:0] HALF_G = SUM_W'(64'd1 << (GAIN_BITS - 1));
    localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'((64'd1 << (S - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] LIM_LO = -LIM_HI - SUM_W'(1);

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_START = 20'h00002,
        S_PREP  = 20'h00004,
        S_RMUL  = 20'h00008,
        S_RDIV  = 20'h00010,
        S_RWAIT = 20'h00020,
        S_WRITE = 20'h00040,
        S_MOD   = 20'h00080,
        S_MWAIT = 20'h00100,
        S_RDA   = 20'h00200,
        S_RDC   = 20'h00400,
        S_MA    = 20'h00800,
        S_MC    = 20'h01000,
        S_IACC  = 20'h02000,
        S_GDIV  = 20'h04000,
        S_GWAIT = 20'h08000,
        S_GMUL  = 20'h10000,
        S_GACC  = 20'h20000,
        S_FIN   = 20'h40000,
        S_OUT   = 20'h80000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [CFG_W-1:0] r_cfg_delay;
    logic [CFG_W-1:0] r_cfg_ovl;
    logic [CFG_W-1:0] r_cfg_ramp;
    logic             r_power;

    // per-buffer state, held by role: recording, decaying, attacking
    logic signed [POS_W-1:0] r_pos_rec, r_pos_dec, r_pos_att;
    logic [LEN_W-1:0]        r_len_rec, r_len_dec, r_len_att;
    logic [IDX_W-1:0]        r_rec_idx;
    logic [1:0]              r_active;
    logic [LEN_W-1:0]        r_pass, r_ovl, r_ramp;

    // working registers of one request
    logic signed [S-1:0]      r_x;
    logic signed [RATE_W-1:0] r_rate;
    logic [IDX_W-1:0]         r_rp;
    logic [LEN_W-1:0]         r_tail;
    logic [LEN_W-1:0]         r_num;
    logic signed [S-1:0]      r_recv;
    logic                     r_role;      // 0 decaying buffer, 1 attacking
    logic [IDX_W-1:0]         r_i, r_j;
    logic [F-1:0]             r_f;
    logic signed [S-1:0]      r_a, r_c;
    logic signed [PW-1:0]     r_prod, r_acc;
    logic signed [S-1:0]      r_interp;
    logic [GAIN_BITS:0]       r_gain;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [S-1:0]      r_res;
    logic signed [S-1:0]      r_out;
    logic                     r_out_valid;

    // ------------------------------------------------------------------
    // pass latch values
    // ------------------------------------------------------------------
    function automatic logic [CW-1:0] limit_span(input logic [CW-1:0] v,
                                                 input logic [CW-1:0] half);
        logic [CW-1:0] t;
        t = (v < CW'(1)) ? CW'(1) : v;
        return (t > half) ? half : t;
    endfunction

    logic [CW-1:0]    delay_c, pass_c, half_c, ramp_c, ovl_c;
    logic [LEN_W-1:0] pass_n;

    always_comb begin
        delay_c = CW'(r_cfg_delay);
        if (delay_c < CW'(2)) begin
            pass_c = CW'(2);
        end else if (delay_c > CW'(BUFFER_DEPTH)) begin
            pass_c = CW'(BUFFER_DEPTH);
        end else begin
            pass_c = delay_c;
        end
        half_c = pass_c >> 1;
        ramp_c = limit_span(CW'(r_cfg_ramp), half_c);
        ovl_c  = limit_span(CW'(r_cfg_ovl), half_c);
        pass_n = LEN_W'(pass_c);
    end

    // ------------------------------------------------------------------
    // roles and positions
    // ------------------------------------------------------------------
    logic [1:0]              bank_dec, bank_att, role_bank;
    logic signed [POS_W-1:0] rate_ext, role_pos, pos_new;
    logic [LEN_W-1:0]        role_len, rp_len, tail_n, gnum, i_len, ip1;
    logic [LF_W-1:0]         role_lf, pnew;
    logic [POS_W-1:0]        pos_mag;
    logic                    pos_neg, gfull;

    logic [DW-1:0] div_a, div_b, div_quo, div_rem;
    logic          div_start;
    t_div_stat     div_stat;

    always_comb begin
        bank_dec  = (r_active == BANK_LAST) ? 2'd0 : r_active + 2'd1;
        bank_att  = (r_active == 2'd0) ? BANK_LAST : r_active - 2'd1;
        rate_ext  = POS_W'(r_rate);
        role_pos  = r_role ? r_pos_att : r_pos_dec;
        role_len  = r_role ? r_len_att : r_len_dec;
        role_bank = r_role ? bank_att : bank_dec;
        role_lf   = {role_len, {F{1'b0}}};
        pos_neg   = role_pos[POS_W-1];
        pos_mag   = pos_neg ? POS_W'(-role_pos) : POS_W'(role_pos);
        rp_len    = LEN_W'(r_rec_idx);
        tail_n    = r_pass - rp_len;
        gnum      = r_role ? LEN_W'(r_rp) : r_tail;
        gfull     = gnum >= r_ovl;
        // floor modulo from the remainder of the magnitude
        if (pos_neg && (div_rem != '0)) begin
            pnew = role_lf - LF_W'(div_rem);
        end else begin
            pnew = LF_W'(div_rem);
        end
        pos_new = POS_W'(pnew);
        i_len   = pnew[LF_W-1:F];
        ip1     = i_len + LEN_W'(1);
    end

    // ------------------------------------------------------------------
    // shared divider
    // ------------------------------------------------------------------
    logic [PW-1:0]       prod_mag;
    logic signed [S-1:0] q_s;

    always_comb begin
        prod_mag  = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
        q_s       = div_quo[S-1:0];
        div_start = (r_state == S_RDIV) || (r_state == S_MOD) ||
                    ((r_state == S_GDIV) && !gfull);
        div_a     = DW'({gnum, {GAIN_BITS{1'b0}}});
        div_b     = DW'(r_ovl);
        if (r_state == S_RDIV) begin
            div_a = DW'(prod_mag);
            div_b = DW'(r_ramp);
        end else if (r_state == S_MOD) begin
            div_a = DW'(pos_mag);
            div_b = DW'(role_lf);
        end
    end

    tbsd_div #(
        .W (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_a),
        .i_divisor   (div_b),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // shared multiplier operands
    // ------------------------------------------------------------------
    logic signed [S-1:0]    mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic [F:0]             one_minus_f;
    logic signed [PW-1:0]   isum;
    logic signed [SUM_W-1:0] fsum, fsh;
    logic signed [S-1:0]    sat;

    always_comb begin
        one_minus_f = {1'b1, {F{1'b0}}} - {1'b0, r_f};
        mul_a = r_x;
        mul_b = MB_W'(r_num);
        case (r_state)
            S_MA: begin
                mul_a = r_a;
                mul_b = MB_W'(one_minus_f);
            end
            S_MC: begin
                mul_a = r_c;
                mul_b = MB_W'(r_f);
            end
            S_GMUL: begin
                mul_a = r_interp;
                mul_b = MB_W'(r_gain);
            end
            default: begin
                mul_a = r_x;
                mul_b = MB_W'(r_num);
            end
        endcase
        isum = r_acc + r_prod + HALF_F;
        fsum = r_sum + HALF_G;
        fsh  = fsum >>> GAIN_BITS;
        if (fsh > LIM_HI) begin
            sat = S'(LIM_HI);
        end else if (fsh < LIM_LO) begin
            sat = S'(LIM_LO);
        end else begin
            sat = S'(fsh);
        end
    end

    // ------------------------------------------------------------------
    // sample store
    // ------------------------------------------------------------------
    t_mem_ctl            mem_ctl;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic signed [S-1:0] mem_rdata;
    logic                clearing;

    always_comb begin
        mem_ctl.we = (r_state == S_WRITE);
        mem_ctl.re = (r_state == S_RDA) || (r_state == S_RDC);
        mem_waddr  = {r_active, r_rp};
        mem_raddr  = (r_state == S_RDC) ? {role_bank, r_j} : {role_bank, r_i};
    end

    // the recording bank is never one of the banks read in the same request,
    // and a request finishes before the next begins: no forwarding needed
    tbsd_store #(
        .IDX_W  (IDX_W),
        .DATA_W (S)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mem_ctl),
        .i_waddr    (mem_waddr),
        .i_wdata    (r_recv),
        .i_raddr    (mem_raddr),
        .o_rdata    (mem_rdata),
        .o_clearing (clearing)
    );

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_delay <= CFG_W'(RESET_DELAY);
            r_cfg_ovl   <= CFG_W'(RESET_SPAN);
            r_cfg_ramp  <= CFG_W'(RESET_SPAN);
            r_power     <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DELAY:   r_cfg_delay <= i_cfg_data;
                REG_OVERLAP: r_cfg_ovl   <= i_cfg_data;
                REG_RAMP:    r_cfg_ramp  <= i_cfg_data;
                REG_POWER:   r_power     <= i_cfg_data[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE) && !clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_rec   <= '0;
            r_pos_dec   <= '0;
            r_pos_att   <= '0;
            r_len_rec   <= LEN_W'(BUFFER_DEPTH);
            r_len_dec   <= LEN_W'(BUFFER_DEPTH);
            r_len_att   <= LEN_W'(BUFFER_DEPTH);
            r_rec_idx   <= '0;
            r_active    <= '0;
            r_pass      <= LEN_W'(BUFFER_DEPTH);
            r_ovl       <= LEN_W'(RESET_SPAN);
            r_ramp      <= LEN_W'(RESET_SPAN);
            r_role      <= 1'b0;
        end else begin
            // drop the taken result; the output state refills it itself
            if (r_out_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_x    <= s_axis_tdata[S-1:0];
                        r_rate <= s_axis_tdata[S+RATE_W-1:S];
                        if (r_power) begin
                            r_state <= S_START;
                        end else begin
                            // power off: zero out, touch nothing
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_START: begin
                    // advance every position; on a pass start rotate roles
                    if (r_rec_idx == '0) begin
                        r_pos_rec <= r_pos_dec + rate_ext;
                        r_pos_dec <= r_pos_att + rate_ext;
                        r_pos_att <= r_pos_rec + rate_ext;
                        r_len_dec <= r_len_att;
                        r_len_att <= r_len_rec;
                        r_active  <= (r_active == BANK_LAST) ? 2'd0 : r_active + 2'd1;
                        r_pass    <= pass_n;
                        r_ovl     <= LEN_W'(ovl_c);
                        r_ramp    <= LEN_W'(ramp_c);
                    end else begin
                        r_pos_rec <= r_pos_rec + rate_ext;
                        r_pos_dec <= r_pos_dec + rate_ext;
                        r_pos_att <= r_pos_att + rate_ext;
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_rp      <= r_rec_idx;
                    r_tail    <= tail_n;
                    r_pos_rec <= r_pos_att;
                    r_len_rec <= r_pass;
                    r_rec_idx <= ((rp_len + LEN_W'(1)) >= r_pass) ? '0
                                                                 : r_rec_idx + IDX_W'(1);
                    r_sum     <= '0;
                    r_role    <= 1'b0;
                    r_recv    <= r_x;
                    // fade in at the head of the pass, fade out at its tail
                    if (rp_len < r_ramp) begin
                        r_num   <= rp_len;
                        r_state <= S_RMUL;
                    end else if (tail_n < r_ramp) begin
                        r_num   <= tail_n;
                        r_state <= S_RMUL;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_RMUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_RDIV;
                end
                S_RDIV: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (div_stat.done) begin
                        // truncate toward zero: divide the magnitude, restore sign
                        r_recv  <= r_prod[PW-1] ? -q_s : q_s;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (div_stat.done) begin
                        if (r_role) begin
                            r_pos_att <= pos_new;
                        end else begin
                            r_pos_dec <= pos_new;
                        end
                        r_i     <= IDX_W'(i_len);
                        r_j     <= (ip1 >= role_len) ? '0 : IDX_W'(ip1);
                        r_f     <= pnew[F-1:0];
                        r_state <= S_RDA;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_a     <= mem_rdata;
                    r_state <= S_MA;
                end
                S_MA: begin
                    r_c     <= mem_rdata;
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_MC;
                end
                S_MC: begin
                    r_acc   <= r_prod;
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_IACC;
                end
                S_IACC: begin
                    r_interp <= S'(isum >>> F);
                    r_state  <= S_GDIV;
                end
                S_GDIV: begin
                    if (gfull) begin
                        r_gain  <= {1'b1, {GAIN_BITS{1'b0}}};
                        r_state <= S_GMUL;
                    end else begin
                        r_state <= S_GWAIT;
                    end
                end
                S_GWAIT: begin
                    if (div_stat.done) begin
                        r_gain  <= div_quo[GAIN_BITS:0];
                        r_state <= S_GMUL;
                    end
                end
                S_GMUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_GACC;
                end
                S_GACC: begin
                    r_sum <= r_sum + SUM_W'(r_prod);
                    if (r_role) begin
                        r_state <= S_FIN;
                    end else begin
                        r_role  <= 1'b1;
                        r_state <= S_MOD;
                    end
                end
                S_FIN: begin
                    r_res   <= sat;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata        = '0;
        m_axis_tdata[S-1:0] = r_out;
    end

`ifndef SYNTHESIS
    a_rec_idx_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (LEN_W'(r_rec_idx) < r_pass))
        else $error("record index outside pass");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> ((r_state == S_RWAIT) || (r_state == S_MWAIT) ||
                           (r_state == S_GWAIT)))
        else $error("divider result with nobody waiting");

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_pos_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDA) |-> (!role_pos[POS_W-1] &&
                                (role_pos[POS_W-2:F] < role_len)))
        else $error("read position not wrapped");
`endif

endmodule

### tb/scrub_delay_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrub_delay_checker
// Watches the sample, result and register channels of the scrub delay. Keeps
// its own copy of the three buffers and the pass state, predicts each playback
// sample and compares it with what the block returns.
// ----------------------------------------------------------------------------
module scrub_delay_checker import tbsd_pkg::*; #(
    parameter int BUFFER_DEPTH = 131072,
    parameter int SAMPLE_BITS  = 24,
    parameter int FRAC_BITS    = 16,
    parameter int SW           = ((SAMPLE_BITS+FRAC_BITS+4+7)/8)*8,
    parameter int MW           = ((SAMPLE_BITS+7)/8)*8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  logic                 i_s_ready,
    input  logic [SW-1:0]        i_s_data,
    input  logic                 i_m_valid,
    input  logic                 i_m_ready,
    input  logic [MW-1:0]        i_m_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int RATE_W = FRAC_BITS + 4;

    logic signed [SAMPLE_BITS-1:0] bank_mem [3*BUFFER_DEPTH];
    longint      play_pos [3];
    int unsigned bank_len [3];
    int unsigned rec_idx, rec_bank, pass_len, cur_overlap, cur_ramp;
    int unsigned delay_r, overlap_r, ramp_r;
    bit          power_r;

    logic [SAMPLE_BITS-1:0] playback_q [$];

    function automatic int unsigned clamp_span(int unsigned v, int unsigned len);
        int unsigned half;
        half = len >> 1;
        if (v < 1) v = 1;
        if (v > half) v = half;
        return v;
    endfunction

    function automatic longint fade_gain(int unsigned num, int unsigned span);
        if (num >= span) return longint'(1) << GAIN_BITS;
        return (longint'(num) << GAIN_BITS) / longint'(span);
    endfunction

    // floor((x + half) / 2^n)
    function automatic longint round_half_up(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // wrap the position of bank b and interpolate between neighbouring samples
    function automatic longint interp_bank(int b);
        int unsigned len;
        longint      lf, p, i, j, f, a, c;
        len = bank_len[b];
        if (len < 1 || len > BUFFER_DEPTH) len = BUFFER_DEPTH;
        lf = longint'(len) << FRAC_BITS;
        p  = play_pos[b] % lf;
        if (p < 0) p += lf;
        play_pos[b] = p;
        i = p >>> FRAC_BITS;
        f = p & ((longint'(1) << FRAC_BITS) - 1);
        j = i + 1;
        if (j >= len) j = 0;
        if (i >= BUFFER_DEPTH) i = 0;
        a = longint'(bank_mem[b*BUFFER_DEPTH + i]);
        c = longint'(bank_mem[b*BUFFER_DEPTH + j]);
        return round_half_up(a * ((longint'(1) << FRAC_BITS) - f) + c * f, FRAC_BITS);
    endfunction

    // advance the model by one request and return the expected playback sample
    function automatic logic [SAMPLE_BITS-1:0] predict_playback(logic [SW-1:0] d);
        logic signed [SAMPLE_BITS-1:0] xs;
        logic signed [RATE_W-1:0]      rs;
        longint      x, rate, rec_val, g_dec, g_att, sum, lim;
        int unsigned dec, att, rp, tail;
        if (!power_r) return '0;
        xs   = d[SAMPLE_BITS-1:0];
        rs   = d[SAMPLE_BITS +: RATE_W];
        x    = longint'(xs);
        rate = longint'(rs);
        for (int k = 0; k < 3; k++) play_pos[k] += rate;

        if (rec_idx == 0) begin
            rec_bank = (rec_bank >= 2) ? 0 : rec_bank + 1;
            pass_len = delay_r;
            if (pass_len < 2) pass_len = 2;
            if (pass_len > BUFFER_DEPTH) pass_len = BUFFER_DEPTH;
            cur_ramp    = clamp_span(ramp_r, pass_len);
            cur_overlap = clamp_span(overlap_r, pass_len);
        end

        dec  = (rec_bank + 1) % 3;
        att  = (rec_bank + 2) % 3;
        rp   = rec_idx;
        tail = pass_len - rp;
        g_dec = fade_gain(tail, cur_overlap);
        g_att = fade_gain(rp, cur_overlap);

        // linear ramp at both ends of the record pass, truncated toward zero
        rec_val = x;
        if (rp < cur_ramp) rec_val = x * longint'(rp) / longint'(cur_ramp);
        else if (tail < cur_ramp) rec_val = x * longint'(tail) / longint'(cur_ramp);
        if (rp < BUFFER_DEPTH) bank_mem[rec_bank*BUFFER_DEPTH + rp] = SAMPLE_BITS'(rec_val);
        rec_idx = rp + 1;
        if (rec_idx >= pass_len) rec_idx = 0;

        bank_len[rec_bank] = pass_len;
        play_pos[rec_bank] = play_pos[att];

        sum = interp_bank(dec) * g_dec;
        sum = sum + interp_bank(att) * g_att;
        sum = round_half_up(sum, GAIN_BITS);
        lim = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (sum > lim) sum = lim;
        if (sum < -lim - 1) sum = -lim - 1;
        return sum[SAMPLE_BITS-1:0];
    endfunction

    initial begin
        for (int k = 0; k < 3*BUFFER_DEPTH; k++) bank_mem[k] = '0;
        for (int k = 0; k < 3; k++) begin
            play_pos[k] = 0;
            bank_len[k] = BUFFER_DEPTH;
        end
        rec_idx     = 0;
        rec_bank    = 0;
        pass_len    = BUFFER_DEPTH;
        cur_overlap = RESET_SPAN;
        cur_ramp    = RESET_SPAN;
        delay_r     = RESET_DELAY;
        overlap_r   = RESET_SPAN;
        ramp_r      = RESET_SPAN;
        power_r     = 1'b1;
        o_fail_count = 0;
        o_checked    = 0;
    end

    assign o_pending = playback_q.size();

    always @(posedge i_clk) begin
        logic [SAMPLE_BITS-1:0] want, got;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_DELAY:   delay_r   = 32'(i_cfg_data);
                    REG_OVERLAP: overlap_r = 32'(i_cfg_data);
                    REG_RAMP:    ramp_r    = 32'(i_cfg_data);
                    REG_POWER:   power_r   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) playback_q.push_back(predict_playback(i_s_data));
            if (i_m_valid && i_m_ready) begin
                got = i_m_data[SAMPLE_BITS-1:0];
                if (playback_q.size() == 0) begin
                    $error("out_sample: unexpected request, expected none, actual %0d",
                           $signed(got));
                    o_fail_count++;
                end else begin
                    want = playback_q.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        $error("out_sample: expected %0d, actual %0d",
                               $signed(want), $signed(got));
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

### tb/triple_buffer_scrub_delay_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_buffer_scrub_delay_tb
// Drives samples and scrub rates through the scrub delay over a series of
// register settings, with random idling on both sides and one long output
// stall, while the checker predicts and compares every playback sample.
// ----------------------------------------------------------------------------
module triple_buffer_scrub_delay_tb;
    import tbsd_pkg::*;

    localparam int BUFFER_DEPTH = 131072;
    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 16;
    localparam int RATE_W       = FRAC_BITS + 4;
    localparam int SW           = ((SAMPLE_BITS+FRAC_BITS+4+7)/8)*8;
    localparam int MW           = ((SAMPLE_BITS+7)/8)*8;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 125;
    localparam int SETTLE       = 300;   // beyond the slowest request

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [SW-1:0]        s_axis_tdata;   // in_sample, scrub_rate, zero fill
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [MW-1:0]        m_axis_tdata;   // out_sample, zero fill
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int  fail_count, pending, checked;
    int  sent;
    bit  quiet;          // no idling in the closing phase
    bit  hold_req;       // ask the receiver for one long stall
    bit  hold_done;

    triple_buffer_scrub_delay #(
        .BUFFER_DEPTH(BUFFER_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)
    ) dut (.*);

    scrub_delay_checker #(
        .BUFFER_DEPTH(BUFFER_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)
    ) checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Limit: the clearing sweep plus every request at its slowest, several times over
    initial begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: short random stall bursts, plus one long hold on request
    initial begin
        int stall_left;
        int long_left;
        stall_left = 0;
        long_left  = 0;
        hold_done  = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                long_left = 400;
                hold_done = 1'b1;
            end
            if (long_left > 0) begin
                long_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until taken; leave valid high afterwards
    task automatic send_sample(logic [SAMPLE_BITS-1:0] smp, logic [RATE_W-1:0] rate);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(SW-SAMPLE_BITS-RATE_W){1'b0}}, rate, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic idle_input(int n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain every outstanding result, then let the block settle
    task automatic drain_block();
        idle_input(1);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: return SAMPLE_BITS'(int'($urandom_range(0, 15)) - 8);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        int signed r;
        case ($urandom_range(0, 9))
            0: return RATE_W'($urandom);                           // any step
            1: return '0;
            2: return RATE_W'(1 << FRAC_BITS);                     // unity
            3: return RATE_W'(-(1 << FRAC_BITS));
            default: begin
                r = int'($urandom_range(0, 4 << FRAC_BITS));       // within two samples
                return RATE_W'(r - (2 << FRAC_BITS));
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_span();
        if ($urandom_range(0, 1)) return CFG_W'($urandom_range(0, 24));
        return CFG_W'($urandom);
    endfunction

    initial begin
        logic [SAMPLE_BITS-1:0] dir_smp [7];
        logic [RATE_W-1:0]      dir_rate [7];
        int burst;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_DELAY;
        i_cfg_data    = '0;
        sent      = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: short pass so pass start, both ramps, crossfade and wrap all show
        write_reg(REG_DELAY, CFG_W'(6));
        write_reg(REG_OVERLAP, CFG_W'(3));
        write_reg(REG_RAMP, CFG_W'(2));
        dir_smp  = '{{1'b0, {23{1'b1}}}, {1'b1, {23{1'b0}}}, 24'd0, {24{1'b1}},
                     24'd1, 24'h555555, 24'haaaaaa};
        dir_rate = '{{1'b0, {19{1'b1}}}, {1'b1, {19{1'b0}}}, 20'd0, 20'd1,
                     {20{1'b1}}, 20'h10000, 20'hf0000};
        for (int k = 0; k < 21; k++) send_sample(dir_smp[k % 7], dir_rate[(k / 3) % 7]);
        drain_block();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin                                   // smallest settings
                    write_reg(REG_DELAY, CFG_W'(2));
                    write_reg(REG_OVERLAP, CFG_W'(1));
                    write_reg(REG_RAMP, CFG_W'(1));
                end
                1: begin                                   // below range, clamped up
                    write_reg(REG_DELAY, CFG_W'(0));
                    write_reg(REG_OVERLAP, CFG_W'(0));
                    write_reg(REG_RAMP, CFG_W'(0));
                end
                2: begin                                   // full depth
                    write_reg(REG_DELAY, CFG_W'(BUFFER_DEPTH));
                    write_reg(REG_OVERLAP, CFG_W'(BUFFER_DEPTH));
                    write_reg(REG_RAMP, CFG_W'(BUFFER_DEPTH));
                end
                3: begin                                   // all ones, clamped down
                    write_reg(REG_DELAY, '1);
                    write_reg(REG_OVERLAP, '1);
                    write_reg(REG_RAMP, '1);
                end
                4: write_reg(REG_POWER, CFG_W'(0));        // frozen, zero output
                default: begin
                    write_reg(REG_POWER, CFG_W'(1));
                    write_reg(REG_DELAY, $urandom_range(0, 1) ? CFG_W'($urandom_range(2, 48))
                                                              : CFG_W'($urandom));
                    write_reg(REG_OVERLAP, pick_span());
                    write_reg(REG_RAMP, pick_span());
                end
            endcase
            quiet    = (ph == PHASES - 1);
            hold_req = (ph == 6);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_sample(pick_sample(), pick_rate());
                if (!quiet && $urandom_range(0, 5) == 0) begin
                    burst = $urandom_range(1, 3);
                    idle_input(burst);
                end
            end
            drain_block();
        end

        $display("Run covered %0d requests and %0d checked results over %0d settings,",
                 sent, checked, PHASES + 1);
        $display("including minimum, clamped, full depth and power off passes.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
